// ===== rtl/smset_pkg.sv =====
// Shared types and codes for the sorted membership set.
// No dependencies; used by smset_ctrl and sorted_membership_set_unit.
package smset_pkg;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_RESET = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SORT_LOAD,
    ST_SORT_FIRST,
    ST_SORT_RUN,
    ST_SORT_END,
    ST_SRCH_START,
    ST_SRCH_CMP,
    ST_FINISH
  } state_t;

  // Result handed from the controller to the output register.
  typedef struct packed {
    logic valid;
    logic found;
    logic status;
  } res_t;

  localparam int ValueWidth = 64;
  localparam int CapWidth   = 7;

endpackage

// ===== rtl/smset_mem.sv =====
// Entry store: single write port, single read port, registered read data.
// Standalone; instantiated by sorted_membership_set_unit.
module smset_mem #(
  parameter int DEPTH = 64,
  parameter int W     = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/smset_ctrl.sv =====
// Command sequencer: append, lazy bubble sort through the store, binary search.
// Depends on smset_pkg; drives the write and read ports of smset_mem.
module smset_ctrl #(
  parameter int DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          command,
  input  logic signed [smset_pkg::ValueWidth-1:0] value,
  input  logic [smset_pkg::CapWidth-1:0]      capacity,
  input  logic                                out_free,
  output smset_pkg::res_t                     res,
  output logic                                mem_we,
  output logic [$clog2(DEPTH)-1:0]            mem_waddr,
  output logic [smset_pkg::ValueWidth-1:0]    mem_wdata,
  output logic [$clog2(DEPTH)-1:0]            mem_raddr,
  input  logic [smset_pkg::ValueWidth-1:0]    mem_rdata
);
  import smset_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > CapWidth) ? CW : CapWidth;

  state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic sorted, sorted_next;
  logic signed [ValueWidth-1:0] value_r;
  logic [IW-1:0] k, k_next;
  logic [IW-1:0] last, last_next;
  logic [ValueWidth-1:0] carry, carry_next;
  logic moved, moved_next;
  logic [CW-1:0] lo, lo_next, hi, hi_next;
  logic [CW-1:0] mid, mid_n;
  logic res_found, res_found_next, res_status, res_status_next;
  logic done, done_found, done_status;
  logic [LW-1:0] limit, cap_ext, count_ext;
  logic full, accept;

  assign cap_ext   = LW'(capacity);
  assign count_ext = LW'(count);
  assign limit     = (cap_ext < LW'(DEPTH)) ? cap_ext : LW'(DEPTH);
  assign full      = (count_ext >= limit);
  assign mid       = lo + ((hi - lo) >> 1);
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      sorted <= 1'b1;
    end else begin
      state  <= state_next;
      count  <= count_next;
      sorted <= sorted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_r <= value;
    end
    k          <= k_next;
    last       <= last_next;
    carry      <= carry_next;
    moved      <= moved_next;
    lo         <= lo_next;
    hi         <= hi_next;
    res_found  <= res_found_next;
    res_status <= res_status_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    sorted_next     = sorted;
    k_next          = k;
    last_next       = last;
    carry_next      = carry;
    moved_next      = moved;
    lo_next         = lo;
    hi_next         = hi;
    mid_n           = mid;
    res_found_next  = res_found;
    res_status_next = res_status;
    done            = 1'b0;
    done_found      = 1'b0;
    done_status     = 1'b0;
    in_ready        = (state == ST_IDLE);
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = carry;
    mem_raddr       = '0;
    res             = '0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (command)
            CMD_ADD: begin
              done = 1'b1;
              if (full) begin
                done_status = 1'b1;
              end else begin
                mem_we      = 1'b1;
                mem_waddr   = count[IW-1:0];
                mem_wdata   = value;
                count_next  = count + 1'b1;
                sorted_next = 1'b0;
              end
            end
            CMD_QUERY: begin
              sorted_next = 1'b1;
              lo_next     = '0;
              hi_next     = count;
              if (!sorted && count >= CW'(2)) begin
                last_next  = IW'(count - 1'b1);
                state_next = ST_SORT_LOAD;
              end else begin
                state_next = ST_SRCH_START;
              end
            end
            CMD_RESET: begin
              count_next  = '0;
              sorted_next = 1'b1;
              done        = 1'b1;
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end

      ST_SORT_LOAD: begin
        mem_raddr  = '0;
        state_next = ST_SORT_FIRST;
      end

      ST_SORT_FIRST: begin
        carry_next = mem_rdata;
        mem_raddr  = IW'(1);
        k_next     = '0;
        moved_next = 1'b0;
        state_next = ST_SORT_RUN;
      end

      // Carry the running maximum up the pass; write the smaller one behind it.
      // The write at k never meets the read at k+2.
      ST_SORT_RUN: begin
        mem_we    = 1'b1;
        mem_waddr = k;
        if ($signed(mem_rdata) < $signed(carry)) begin
          mem_wdata  = mem_rdata;
          moved_next = 1'b1;
        end else begin
          mem_wdata  = carry;
          carry_next = mem_rdata;
        end
        mem_raddr = k + IW'(2);
        k_next    = k + 1'b1;
        if (IW'(k + 1'b1) == last) begin
          state_next = ST_SORT_END;
        end
      end

      ST_SORT_END: begin
        mem_we    = 1'b1;
        mem_waddr = last;
        mem_wdata = carry;
        last_next = last - 1'b1;
        if (!moved || last == IW'(1)) begin
          state_next = ST_SRCH_START;
        end else begin
          state_next = ST_SORT_LOAD;
        end
      end

      ST_SRCH_START: begin
        if (lo < hi) begin
          mem_raddr  = mid[IW-1:0];
          state_next = ST_SRCH_CMP;
        end else begin
          done = 1'b1;
        end
      end

      // Compare, narrow the window and issue the next probe in the same cycle.
      ST_SRCH_CMP: begin
        if (mem_rdata == value_r) begin
          done       = 1'b1;
          done_found = 1'b1;
        end else begin
          if (value_r < $signed(mem_rdata)) begin
            hi_next = mid;
          end else begin
            lo_next = CW'(mid + 1'b1);
          end
          mid_n = lo_next + ((hi_next - lo_next) >> 1);
          if (lo_next < hi_next) begin
            mem_raddr = mid_n[IW-1:0];
          end else begin
            done = 1'b1;
          end
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          res.valid  = 1'b1;
          res.found  = res_found;
          res.status = res_status;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // Hand the result over, or hold it while the output register is busy.
    if (done) begin
      if (out_free) begin
        res.valid  = 1'b1;
        res.found  = done_found;
        res.status = done_status;
        state_next = ST_IDLE;
      end else begin
        res_found_next  = done_found;
        res_status_next = done_status;
        state_next      = ST_FINISH;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    LW'(count) <= LW'(DEPTH))
    else $error("entry count beyond store depth");

  a_res_slot: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> out_free)
    else $error("result issued while output register full");

  a_add_unsorted: assert property (@(posedge clk) disable iff (rst)
    (accept && command == CMD_ADD && !full) |=> !sorted)
    else $error("accepted add left store marked sorted");

  a_sort_port: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SORT_RUN && IW'(k + 1'b1) != last) |-> (mem_waddr != mem_raddr))
    else $error("sort pass reads the entry it writes");

  a_srch_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SRCH_CMP) |-> (lo < hi && hi <= count))
    else $error("search window out of range");

endmodule

// ===== rtl/sorted_membership_set_unit.sv =====
// Top level of the sorted membership set: capacity register, output register,
// controller and entry store. Depends on smset_pkg, smset_mem, smset_ctrl.
//
//   channel   signals                              direction
//   input     in_valid, in_ready, command, value    into the block
//   result    out_valid, out_ready, found, status   out of the block
//   config    cfg_we, cfg_data (capacity)           into the block
//
// Add, reset and unused commands complete from the idle state. A query on a
// sorted store goes straight to the search (one store read per search step).
// A query after adds first sorts: each pass runs through the store's write
// and read ports, up to n - 1 passes.
// Reset empties the set and sets capacity to 64; the store itself is not cleared.
// A new transaction is taken in idle even while a result waits in out_valid;
// its own result then holds until the output register frees.
module sorted_membership_set_unit #(
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [1:0]                              command,
  input  logic signed [smset_pkg::ValueWidth-1:0] value,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    found,
  output logic                                    status,
  input  logic                                    cfg_we,
  input  logic [smset_pkg::CapWidth-1:0]          cfg_data
);
  import smset_pkg::*;

  localparam int IW = $clog2(DEPTH);

  logic [CapWidth-1:0] capacity;
  logic out_free;
  res_t res;
  logic mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic [ValueWidth-1:0] mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CapWidth'(64);
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      found  <= res.found;
      status <= res.status;
    end
  end

  smset_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .value     (value),
    .capacity  (capacity),
    .out_free  (out_free),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  smset_mem #(
    .DEPTH(DEPTH),
    .W    (ValueWidth)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
